### rtl/jsu_pkg.sv
// jsu_pkg: shared types and constants for the json string unescaper
// no dependencies; imported by the top level
package jsu_pkg;

  localparam int CHAR_W = 16;
  localparam int ACC_W  = 12;
  localparam int CHAR_BITS = 16;

  // only the low CHAR_BITS bits of an input character take part
  localparam logic [CHAR_W-1:0] CHAR_MASK =
    (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} : CHAR_W'((64'd1 << CHAR_BITS) - 64'd1);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_HEX     = 2'd1,
    ERR_ESCAPE  = 2'd2,
    ERR_NOQUOTE = 2'd3
  } err_t;

  localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_BS     = 16'h0008;
  localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_LF     = 16'h000a;
  localparam logic [CHAR_W-1:0] CH_FF     = 16'h000c;
  localparam logic [CHAR_W-1:0] CH_CR     = 16'h000d;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002f;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005c;
  localparam logic [CHAR_W-1:0] CH_LC_B   = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_LC_F   = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 16'h006e;
  localparam logic [CHAR_W-1:0] CH_LC_R   = 16'h0072;
  localparam logic [CHAR_W-1:0] CH_LC_T   = 16'h0074;
  localparam logic [CHAR_W-1:0] CH_LC_U   = 16'h0075;

  localparam logic [1:0] LAST_HEX_IDX = 2'd3;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### rtl/jsu_in_if.sv
// jsu_in_if: input channel carrying one string character per word
// no dependencies
interface jsu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

### rtl/jsu_out_if.sv
// jsu_out_if: result channel carrying a decoded character or an end marker
// no dependencies
interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_out;
  logic        is_end;
  logic [1:0]  error_code;

  modport source (output valid, output char_out, output is_end, output error_code,
                  input ready);
  modport sink   (input valid, input char_out, input is_end, input error_code,
                  output ready);
endinterface

### rtl/json_string_unescaper_unit.sv
// json_string_unescaper_unit: decodes json string escapes one character per cycle while result is not stalled
// depends on jsu_pkg, jsu_in_if, jsu_out_if
//
//   port     dir   word
//   chars    in    char_in (16)
//   result   out   char_out (16), is_end, error_code (2)
//
// a character is registered on entry, decoded from the input register and its result
// (if any) lands in the output register; one word per cycle sustained while result
// is not stalled. the escape state lives beside the decode logic and moves as each
// registered character is decoded. synchronous reset clears the valids and the
// escape state. a stall on result holds the output register, and the input
// register keeps taking words while the stalled one needs no result slot.
module json_string_unescaper_unit (
  input  logic         clk,
  input  logic         rst,
  jsu_in_if.sink       chars,
  jsu_out_if.source    result
);
  import jsu_pkg::*;

  // input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;

  // escape state
  mode_t            mode, mode_next;
  logic [1:0]       hex_cnt, hex_cnt_next;
  logic [ACC_W-1:0] hex_acc, hex_acc_next;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_end;
  err_t              out_err;

  // decode result
  logic              res_valid;
  logic [CHAR_W-1:0] res_char;
  logic              res_end;
  err_t              res_err;

  logic [CHAR_W-1:0] c;
  logic [4:0]        hx;
  logic              out_free;
  logic              advance;

  assign c  = in_char & CHAR_MASK;
  assign hx = hex_decode(c);

  // next escape state
  always_comb begin
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    hex_acc_next = hex_acc;
    case (mode)
      MODE_ESCAPE: begin
        mode_next    = MODE_NORMAL;
        hex_cnt_next = 2'd0;
        hex_acc_next = '0;
        if (c == CH_LC_U) begin
          mode_next = MODE_HEX;
        end
      end
      MODE_HEX: begin
        if (hx[4] && hex_cnt != LAST_HEX_IDX) begin
          hex_acc_next = {hex_acc[ACC_W-5:0], hx[3:0]};
          hex_cnt_next = hex_cnt + 2'd1;
        end else begin
          mode_next    = MODE_NORMAL;
          hex_cnt_next = 2'd0;
          hex_acc_next = '0;
        end
      end
      default: begin
        mode_next    = (c == CH_BSLASH) ? MODE_ESCAPE : MODE_NORMAL;
        hex_cnt_next = 2'd0;
        hex_acc_next = '0;
      end
    endcase
  end

  // result of the current character
  always_comb begin
    res_valid = 1'b1;
    res_char  = '0;
    res_end   = 1'b0;
    res_err   = ERR_OK;
    case (mode)
      MODE_ESCAPE: begin
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: res_char = c;
          CH_LC_B: res_char = CH_BS;
          CH_LC_F: res_char = CH_FF;
          CH_LC_N: res_char = CH_LF;
          CH_LC_R: res_char = CH_CR;
          CH_LC_T: res_char = CH_TAB;
          CH_LC_U: res_valid = 1'b0;
          default: begin
            res_end = 1'b1;
            res_err = ERR_ESCAPE;
          end
        endcase
      end
      MODE_HEX: begin
        if (!hx[4]) begin
          res_end = 1'b1;
          res_err = ERR_HEX;
        end else if (hex_cnt != LAST_HEX_IDX) begin
          res_valid = 1'b0;
        end else begin
          res_char = {hex_acc, hx[3:0]} & CHAR_MASK;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          res_end = 1'b1;
          res_err = ERR_OK;
        end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
          res_end = 1'b1;
          res_err = ERR_NOQUOTE;
        end else if (c == CH_BSLASH) begin
          res_valid = 1'b0;
        end else begin
          res_char = c;
        end
      end
    endcase
  end

  assign out_free    = !out_valid || result.ready;
  assign advance     = in_valid && (out_free || !res_valid);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char <= chars.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      hex_cnt <= 2'd0;
      hex_acc <= '0;
    end else if (advance) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      hex_acc <= hex_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_char <= res_char;
      out_end  <= res_end;
      out_err  <= res_err;
    end
  end

  assign result.valid      = out_valid;
  assign result.char_out   = out_char;
  assign result.is_end     = out_end;
  assign result.error_code = out_err;

endmodule

### dv/jsu_checker.sv
// jsu_checker: watches the character and result channels of the string unescaper,
// predicts each decoded word and compares it with what comes out
// depends on jsu_pkg, jsu_in_if, jsu_out_if
module jsu_checker (
  input  logic clk,
  input  logic rst,
  jsu_in_if    chars,
  jsu_out_if   result,
  output int   fail_count,
  output int   pending
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
    err_t              err;
  } decoded_t;

  decoded_t          expected_words [$];
  mode_t             esc_mode;
  logic [1:0]        hex_count;
  logic [ACC_W-1:0]  hex_acc;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // {is digit, value}
  function automatic logic [4:0] hex_digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      v = c - 16'h0030;
      return {1'b1, v[3:0]};
    end
    if (c >= 16'h0061 && c <= 16'h0066) begin
      v = c - 16'h0057;
      return {1'b1, v[3:0]};
    end
    if (c >= 16'h0041 && c <= 16'h0046) begin
      v = c - 16'h0037;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic clear_escape_state();
    esc_mode  = MODE_NORMAL;
    hex_count = '0;
    hex_acc   = '0;
  endtask

  // advances the escape state by one character; made is set when a word comes out
  task automatic decode_char(input logic [CHAR_W-1:0] raw, output bit made,
                             output decoded_t word);
    logic [CHAR_W-1:0] c;
    logic [4:0]        d;
    c    = raw & CHAR_MASK;
    made = 1'b1;
    word = '{ch: '0, fin: 1'b0, err: ERR_OK};
    case (esc_mode)
      MODE_ESCAPE: begin
        esc_mode = MODE_NORMAL;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: word.ch = c;
          CH_LC_B: word.ch = CH_BS;
          CH_LC_F: word.ch = CH_FF;
          CH_LC_N: word.ch = CH_LF;
          CH_LC_R: word.ch = CH_CR;
          CH_LC_T: word.ch = CH_TAB;
          CH_LC_U: begin
            esc_mode  = MODE_HEX;
            hex_count = '0;
            hex_acc   = '0;
            made      = 1'b0;
          end
          default: begin
            word.fin = 1'b1;
            word.err = ERR_ESCAPE;
          end
        endcase
      end
      MODE_HEX: begin
        d = hex_digit_value(c);
        if (!d[4]) begin
          word.fin = 1'b1;
          word.err = ERR_HEX;
        end else if (hex_count != LAST_HEX_IDX) begin
          hex_acc   = {hex_acc[ACC_W-5:0], d[3:0]};
          hex_count = hex_count + 2'd1;
          made      = 1'b0;
        end else begin
          word.ch = {hex_acc, d[3:0]};
          clear_escape_state();
        end
      end
      default: begin
        // the spare mode value behaves as normal
        esc_mode = MODE_NORMAL;
        if (c == CH_QUOTE) begin
          word.fin = 1'b1;
          word.err = ERR_OK;
        end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
          word.fin = 1'b1;
          word.err = ERR_NOQUOTE;
        end else if (c == CH_BSLASH) begin
          esc_mode = MODE_ESCAPE;
          made     = 1'b0;
        end else begin
          word.ch = c;
        end
      end
    endcase
    // any end marker starts a fresh string body
    if (made && word.fin) begin
      clear_escape_state();
    end
  endtask

  always @(posedge clk) begin
    bit       made;
    decoded_t word;
    decoded_t want;
    if (rst) begin
      clear_escape_state();
      expected_words.delete();
    end else begin
      // compare before pushing so a word cannot match its own cause
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word: char %h end %0d err %0d",
                                    result.char_out, result.is_end, result.error_code));
        end else begin
          want = expected_words.pop_front();
          if (result.char_out !== want.ch) begin
            report_mismatch($sformatf("char_out %h, expected %h", result.char_out, want.ch));
          end
          if (result.is_end !== want.fin) begin
            report_mismatch($sformatf("is_end %0d, expected %0d", result.is_end, want.fin));
          end
          if (result.error_code !== want.err) begin
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      result.error_code, want.err));
          end
        end
      end
      if (chars.valid && chars.ready) begin
        decode_char(chars.char_in, made, word);
        if (made) begin
          expected_words.push_back(word);
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

### dv/testbench.sv
// testbench: drives strings into json_string_unescaper_unit with random gaps and stalls
// depends on jsu_pkg, jsu_in_if, jsu_out_if, the unit itself and jsu_checker
module testbench;
  import jsu_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_WORDS  = 310;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct = 9;
  int   recv_idle_pct = 63;
  int   sent_words = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  logic [CHAR_W-1:0] directed_words [$];

  jsu_in_if  chars_if ();
  jsu_out_if result_if ();

  json_string_unescaper_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  jsu_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .result     (result_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(input logic [CHAR_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid   <= 1'b1;
    chars_if.char_in <= w;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] plain_word();
    logic [CHAR_W-1:0] w;
    w = $urandom_range(1) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(16'h20, 16'h7e));
    while (w inside {CH_QUOTE, CH_BSLASH, CH_CR, CH_LF, CH_NUL}) begin
      w = CHAR_W'($urandom);
    end
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_word();
    int v;
    v = $urandom_range(15);
    if (v < 10) begin
      return CHAR_W'(16'h30 + v);
    end
    return $urandom_range(1) ? CHAR_W'(16'h61 + v - 10) : CHAR_W'(16'h41 + v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] escape_letter();
    case ($urandom_range(7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_LC_B;
      4:       return CH_LC_F;
      5:       return CH_LC_N;
      6:       return CH_LC_R;
      default: return CH_LC_T;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] bad_escape_word();
    logic [CHAR_W-1:0] w;
    case ($urandom_range(4))
      0: w = CH_CR;
      1: w = CH_LF;
      2: w = CH_NUL;
      default: begin
        w = CHAR_W'($urandom_range(16'h20, 16'h7e));
        while (w inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F, CH_LC_N,
                         CH_LC_R, CH_LC_T, CH_LC_U}) begin
          w = $urandom_range(1) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(16'h20, 16'h7e));
        end
      end
    endcase
    return w;
  endfunction

  // near misses around the digit ranges, plus anything else
  function automatic logic [CHAR_W-1:0] bad_hex_word();
    logic [CHAR_W-1:0] w;
    case ($urandom_range(9))
      0: w = 16'h002f;
      1: w = 16'h003a;
      2: w = 16'h0040;
      3: w = 16'h0047;
      4: w = 16'h0060;
      5: w = 16'h0067;
      6: w = CH_QUOTE;
      7: w = CH_NUL;
      default: begin
        w = CHAR_W'($urandom);
        while (w inside {[16'h30:16'h39], [16'h41:16'h46], [16'h61:16'h66]}) begin
          w = CHAR_W'($urandom);
        end
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_word();
    case ($urandom_range(7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_LC_U;
      3:       return CH_CR;
      4:       return CH_LF;
      5:       return CH_NUL;
      6:       return hex_word();
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  // one string body: mostly well formed, sometimes cut short by an error
  task automatic send_string();
    int pieces;
    int kind;
    int digits;
    pieces = $urandom_range(6);
    repeat (pieces) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_word(plain_word());
      end else if (kind < 80) begin
        send_word(CH_BSLASH);
        send_word(escape_letter());
      end else begin
        send_word(CH_BSLASH);
        send_word(CH_LC_U);
        repeat (4) send_word(hex_word());
      end
    end
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_word(CH_QUOTE);
    end else if (kind < 76) begin
      send_word(CH_CR);
    end else if (kind < 82) begin
      send_word(CH_LF);
    end else if (kind < 86) begin
      send_word(CH_NUL);
    end else if (kind < 93) begin
      send_word(CH_BSLASH);
      send_word(bad_escape_word());
    end else begin
      send_word(CH_BSLASH);
      send_word(CH_LC_U);
      digits = $urandom_range(3);
      repeat (digits) send_word(hex_word());
      send_word(bad_hex_word());
    end
  endtask

  initial begin
    int target;
    rst              <= 1'b1;
    chars_if.valid   <= 1'b0;
    chars_if.char_in <= '0;
    directed_words = '{
      16'hffff, 16'h0001,
      CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
      CH_BSLASH, CH_LC_B, CH_BSLASH, CH_LC_F, CH_BSLASH, CH_LC_N,
      CH_BSLASH, CH_LC_R, CH_BSLASH, CH_LC_T,
      CH_BSLASH, CH_LC_U, 16'h0046, 16'h0061, 16'h0039, 16'h0030,
      CH_QUOTE, CH_CR,
      CH_BSLASH, CH_LF,
      CH_BSLASH, CH_LC_U, 16'h0031, CH_QUOTE,
      CH_NUL
    };
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) send_word(directed_words[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 9;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: begin
          send_idle_pct = 9;
          recv_idle_pct = 63;
        end
      endcase
      target = sent_words + PHASE_WORDS;
      while (sent_words < target) begin
        // stray characters leave the decoder in whatever state they reach
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4)) send_word(noise_word());
        end
        send_string();
      end
    end
    chars_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/json_string_unescaper_unit.sv
dv/jsu_checker.sv
dv/testbench.sv
